// File: sv/rcpm_pkg.sv
// shared types, widths and codes of the rms current power meter
`timescale 1ns / 1ps
package rcpm_pkg;

  localparam int DEF_COUNT_W  = 16;
  localparam int DEF_SAMPLE_W = 16;
  localparam int MAX_PARAM_W  = 24;

  localparam int SUM_W   = 48;
  localparam int RT_W    = SUM_W / 2;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int SAMP_W  = 16;
  localparam int RMS_W   = 16;
  localparam int CUR_W   = 31;
  localparam int PWR_W   = 40;
  localparam int WCNT_W  = 16;
  localparam int SCALE_W = 16;
  localparam int VOLT_W  = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1875);
  localparam logic [VOLT_W-1:0]  VOLT_RST  = VOLT_W'(230);
  localparam int                 MW_DIV    = 1000;

  // reciprocals for the divide by 1000 in the power path
  localparam int                    RCP_CUR_W  = 32;
  localparam logic [RCP_CUR_W-1:0]  RCP_CUR    = 32'd2199023256;
  localparam int                    RCP_CUR_SH = 41;
  localparam int                    RCP_MW_W   = 20;
  localparam logic [RCP_MW_W-1:0]   RCP_MW     = 20'd536871;
  localparam int                    RCP_MW_SH  = 29;
  localparam int                    PQ_W       = CUR_W + RCP_CUR_W - RCP_CUR_SH;
  localparam int                    PREM_W     = 10;
  localparam int                    PRV_W      = PREM_W + VOLT_W;
  localparam int                    PHI_W      = PQ_W + VOLT_W;
  localparam int                    PFRAC_W    = PRV_W + RCP_MW_W - RCP_MW_SH;
  localparam int                    PWR_STEPS  = 4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLOSE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VOLT  = CFG_IDX_W'(1);

  typedef struct packed {
    logic cap_sample;
    logic square;
    logic accum;
    logic close;
    logic div_step;
    logic sqrt_step;
    logic mul_cur;
    logic mul_pwr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_empty;
  } dp_sts_t;

endpackage

// File: sv/rcpm_dpath.sv
// datapath: accumulator, divider, square root, scaling and result word
`timescale 1ns / 1ps
module rcpm_dpath import rcpm_pkg::*; #(
  parameter int COUNT_WIDTH  = DEF_COUNT_W,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_sts_t                   sts,
  input  logic signed [SAMP_W-1:0]  in_sample,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  output logic [RMS_W-1:0]          out_rms_raw,
  output logic [CUR_W-1:0]          out_current_ua,
  output logic [PWR_W-1:0]          out_power_mw,
  output logic [WCNT_W-1:0]         out_window_count,
  output logic                      out_window_empty,
  output logic                      out_saturated
);

  localparam int DV_W = COUNT_WIDTH;

  logic [SCALE_W-1:0]        scale_r;
  logic [VOLT_W-1:0]         volt_r;
  logic [SAMPLE_WIDTH-1:0]   mag_r;
  logic [2*SAMPLE_WIDTH-1:0] sq_r;
  logic [SUM_W-1:0]          sum_r;
  logic [COUNT_WIDTH-1:0]    total_r;
  logic                      ovf_r;
  logic [WCNT_W-1:0]         cnt_hold_r;
  logic                      empty_hold_r;
  logic                      sat_hold_r;
  logic [SUM_W-1:0]          quo_r;
  logic [DV_W-1:0]           divisor_r;
  logic [DV_W-1:0]           div_rem_r;
  logic [RT_W+1:0]           sq_rem_r;
  logic [RT_W-1:0]           root_r;
  logic [RMS_W-1:0]          rms_r;
  logic [CUR_W-1:0]          cur_r;
  logic [PQ_W-1:0]           pq_r;
  logic [PREM_W-1:0]         prem_r;
  logic [PHI_W-1:0]          phi_r;
  logic [PRV_W-1:0]          prv_r;
  logic [PFRAC_W-1:0]        pfrac_r;

  logic [MAX_PARAM_W-1:0]    samp_wide;
  logic [SAMPLE_WIDTH-1:0]   raw;
  logic [SAMPLE_WIDTH-1:0]   mag;
  logic [SUM_W:0]            sum_add;
  logic [MAX_PARAM_W-1:0]    total_wide;
  logic [WCNT_W-1:0]         cnt_sat;
  logic [DV_W:0]             div_sh;
  logic                      div_ge;
  logic [DV_W:0]             div_diff;
  logic [RT_W+3:0]           sqrt_sh;
  logic [RT_W+3:0]           sqrt_trial;
  logic                      sqrt_ge;
  logic [RT_W+3:0]           sqrt_diff;
  logic [RMS_W-1:0]          rms_sat;
  logic [2*RMS_W-1:0]        cur_prod;
  logic [CUR_W+RCP_CUR_W-1:0] pq_prod;
  logic [CUR_W-1:0]          pq_back;
  logic [CUR_W-1:0]          prem_full;
  logic [PRV_W+RCP_MW_W-1:0] pf_prod;
  logic [PWR_W-1:0]          pwr_sum;

  always_comb begin
    samp_wide  = MAX_PARAM_W'($unsigned(in_sample));
    raw        = samp_wide[SAMPLE_WIDTH-1:0];
    mag        = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
    sum_add    = {1'b0, sum_r} + {1'b0, SUM_W'(sq_r)};
    total_wide = MAX_PARAM_W'(total_r);
    cnt_sat    = (|total_wide[MAX_PARAM_W-1:WCNT_W]) ? '1 : total_wide[WCNT_W-1:0];
    div_sh     = {div_rem_r, quo_r[SUM_W-1]};
    div_ge     = div_sh >= {1'b0, divisor_r};
    div_diff   = div_sh - {1'b0, divisor_r};
    sqrt_sh    = {sq_rem_r, quo_r[SUM_W-1:SUM_W-2]};
    sqrt_trial = (RT_W+4)'({root_r, 2'b01});
    sqrt_ge    = sqrt_sh >= sqrt_trial;
    sqrt_diff  = sqrt_sh - sqrt_trial;
    rms_sat    = (|root_r[RT_W-1:RMS_W]) ? '1 : root_r[RMS_W-1:0];
    cur_prod   = rms_sat * scale_r;
    pq_prod    = cur_r * RCP_CUR;
    pq_back    = pq_r * CUR_W'(MW_DIV);
    prem_full  = cur_r - pq_back;
    pf_prod    = prv_r * RCP_MW;
    pwr_sum    = PWR_W'(phi_r) + PWR_W'(pfrac_r);
  end

  assign sts.acc_empty = (total_r == '0);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      volt_r  <= VOLT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SCALE) begin
        scale_r <= cfg_wdata[SCALE_W-1:0];
      end else if (cfg_index == REG_VOLT) begin
        volt_r <= cfg_wdata[VOLT_W-1:0];
      end
    end
  end

  // window accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.close) begin
      sum_r   <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accum) begin
      if (total_r == '1) begin
        ovf_r <= 1'b1;
      end else begin
        total_r <= total_r + 1'b1;
        if (sum_add[SUM_W]) begin
          sum_r <= '1;
          ovf_r <= 1'b1;
        end else begin
          sum_r <= sum_add[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_sample) begin
      mag_r <= mag;
    end
    if (cmd.square) begin
      sq_r <= mag_r * mag_r;
    end
  end

  // divider, square root and scaling
  always_ff @(posedge clk) begin
    if (cmd.close) begin
      cnt_hold_r   <= cnt_sat;
      empty_hold_r <= (total_r == '0);
      sat_hold_r   <= ovf_r;
      quo_r        <= sum_r;
      divisor_r    <= DV_W'(total_r);
      div_rem_r    <= '0;
      sq_rem_r     <= '0;
      root_r       <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[SUM_W-2:0], div_ge};
      div_rem_r <= div_ge ? div_diff[DV_W-1:0] : div_sh[DV_W-1:0];
    end else if (cmd.sqrt_step) begin
      quo_r    <= {quo_r[SUM_W-3:0], 2'b00};
      sq_rem_r <= sqrt_ge ? sqrt_diff[RT_W+1:0] : sqrt_sh[RT_W+1:0];
      root_r   <= {root_r[RT_W-2:0], sqrt_ge};
    end else if (cmd.mul_cur) begin
      rms_r <= rms_sat;
      cur_r <= cur_prod[2*RMS_W-1] ? '1 : cur_prod[CUR_W-1:0];
    end else if (cmd.mul_pwr) begin
      // current = 1000 q + r, power = q v + (r v) / 1000
      pq_r    <= pq_prod[CUR_W+RCP_CUR_W-1:RCP_CUR_SH];
      prem_r  <= prem_full[PREM_W-1:0];
      phi_r   <= pq_r * volt_r;
      prv_r   <= prem_r * volt_r;
      pfrac_r <= pf_prod[PRV_W+RCP_MW_W-1:RCP_MW_SH];
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rms_raw      <= empty_hold_r ? '0 : rms_r;
      out_current_ua   <= empty_hold_r ? '0 : cur_r;
      out_power_mw     <= empty_hold_r ? '0 : pwr_sum;
      out_window_count <= cnt_hold_r;
      out_window_empty <= empty_hold_r;
      out_saturated    <= sat_hold_r;
    end
  end

endmodule

// File: sv/rcpm_ctrl.sv
// controller: sequences sample accumulation and the window-end computation
`timescale 1ns / 1ps
module rcpm_ctrl import rcpm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_ACC     = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_SQRT    = 4'd4;
  localparam logic [3:0] S_MUL_CUR = 4'd5;
  localparam logic [3:0] S_MUL_PWR = 4'd6;
  localparam logic [3:0] S_SCALE   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              div_last;
  logic              sqrt_last;
  logic              pwr_last;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign div_last  = (step_r == STEP_W'(SUM_W - 1));
  assign sqrt_last = (step_r == STEP_W'(RT_W - 1));
  assign pwr_last  = (step_r == STEP_W'(PWR_STEPS - 2));

  always_comb begin
    cmd            = '0;
    cmd.cap_sample = accept && (in_cmd == CMD_SAMPLE);
    cmd.close      = accept && (in_cmd == CMD_CLOSE);
    cmd.square     = (state_r == S_SQ);
    cmd.accum      = (state_r == S_ACC);
    cmd.div_step   = (state_r == S_DIV);
    cmd.sqrt_step  = (state_r == S_SQRT);
    cmd.mul_cur    = (state_r == S_MUL_CUR);
    cmd.mul_pwr    = (state_r == S_MUL_PWR) || (state_r == S_SCALE);
    cmd.load_out   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (cmd.cap_sample) begin
          state_nxt = S_SQ;
        end else if (cmd.close) begin
          state_nxt = sts.acc_empty ? S_DONE : S_DIV;
        end
      end
      S_SQ:  state_nxt = S_ACC;
      S_ACC: state_nxt = S_IDLE;
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (div_last) begin
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        step_nxt = step_r + 1'b1;
        if (sqrt_last) begin
          step_nxt  = '0;
          state_nxt = S_MUL_CUR;
        end
      end
      S_MUL_CUR: state_nxt = S_MUL_PWR;
      S_MUL_PWR: state_nxt = S_SCALE;
      S_SCALE: begin
        step_nxt = step_r + 1'b1;
        if (pwr_last) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd.load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("block idle right after taking a word");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwritten while output word still waits");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (step_r < STEP_W'(RT_W)))
    else $error("square root step count out of range");

endmodule

// File: sv/rms_current_power_meter_unit.sv
// top level of the rms current power meter
// Usage:
// - input word: in_cmd selects sample (0) or window close (1), in_sample is the
//   signed adc reading; taken when in_valid is high and in_stall is low
// - a sample word passes through capture, square and accumulate; the block
//   stalls the input meanwhile and returns no result word
// - a window close word runs through the accepting cycle, a one-bit-per-cycle
//   divider (sum over count), the square root (two bits per cycle), one current
//   multiply, the reciprocal multiplies for power over 1000 and one load
// - an empty window skips the arithmetic and reports zeros with window_empty set
// - the result word sits in an output register; out_valid rises in the cycle
//   after the load and holds with its payload while out_stall is high
// - samples are taken while a result word waits; a further close waits for
//   the output register to free up before loading
// - cfg_we writes register cfg_index (0 scale, 1 voltage); write it only while the block idles (unenforced)
// - synchronous reset clears the accumulator, the sequencer and out_valid and
//   restores the register defaults
`timescale 1ns / 1ps
module rms_current_power_meter_unit import rcpm_pkg::*; #(
  parameter int COUNT_WIDTH  = DEF_COUNT_W,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic signed [SAMP_W-1:0]  in_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RMS_W-1:0]          out_rms_raw,
  output logic [CUR_W-1:0]          out_current_ua,
  output logic [PWR_W-1:0]          out_power_mw,
  output logic [WCNT_W-1:0]         out_window_count,
  output logic                      out_window_empty,
  output logic                      out_saturated,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rcpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rcpm_dpath #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_rms_raw      (out_rms_raw),
    .out_current_ua   (out_current_ua),
    .out_power_mw     (out_power_mw),
    .out_window_count (out_window_count),
    .out_window_empty (out_window_empty),
    .out_saturated    (out_saturated)
  );

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the rms current power meter: directed and random windows
`timescale 1ns / 1ps
module tb_top;
  import rcpm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED3 = CFG_IDX_W'(3);

  localparam longint unsigned SUM_FULL   = (64'd1 << SUM_W) - 1;
  localparam longint unsigned COUNT_FULL = (64'd1 << DEF_COUNT_W) - 1;
  localparam longint unsigned RMS_FULL   = (64'd1 << RMS_W) - 1;
  localparam longint unsigned CUR_FULL   = (64'd1 << CUR_W) - 1;
  localparam longint unsigned WCNT_FULL  = (64'd1 << WCNT_W) - 1;

  localparam int RAND_WORDS  = 1000;
  localparam int CFG_SETTLE  = 16;
  localparam int END_SETTLE  = 150;
  localparam int LIMIT_NS    = 2_000_000;

  typedef struct {
    logic [RMS_W-1:0]  rms_raw;
    logic [CUR_W-1:0]  current_ua;
    logic [PWR_W-1:0]  power_mw;
    logic [WCNT_W-1:0] window_count;
    logic              window_empty;
    logic              saturated;
  } report_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_cmd;
  logic signed [SAMP_W-1:0] in_sample;
  logic                     out_valid;
  logic                     out_stall;
  logic [RMS_W-1:0]         out_rms_raw;
  logic [CUR_W-1:0]         out_current_ua;
  logic [PWR_W-1:0]         out_power_mw;
  logic [WCNT_W-1:0]        out_window_count;
  logic                     out_window_empty;
  logic                     out_saturated;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;

  report_t           report_q[$];
  report_t           want_r;
  longint unsigned   acc_sum;
  longint unsigned   acc_count;
  logic              acc_over;
  logic [SCALE_W-1:0] scale_reg;
  logic [VOLT_W-1:0]  volt_reg;

  int   errors;
  int   words_sent;
  int   burst_left;
  int   gap_max;
  int   hold_len;
  logic hold_go;

  rms_current_power_meter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rms_raw      (out_rms_raw),
    .out_current_ua   (out_current_ua),
    .out_power_mw     (out_power_mw),
    .out_window_count (out_window_count),
    .out_window_empty (out_window_empty),
    .out_saturated    (out_saturated),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = RT_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void track_word(input logic cmd, input logic signed [SAMP_W-1:0] samp);
    int              s;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned rms;
    longint unsigned cur;
    longint unsigned pwr;
    report_t         r;
    if (cmd == CMD_SAMPLE) begin
      s = samp;
      mag = (s < 0) ? -s : s;
      sq = mag * mag;
      if (acc_count >= COUNT_FULL) begin
        acc_over = 1'b1;
      end else begin
        acc_count++;
        if (sq > SUM_FULL - acc_sum) begin
          acc_sum = SUM_FULL;
          acc_over = 1'b1;
        end else begin
          acc_sum += sq;
        end
      end
    end else begin
      rms = 0;
      cur = 0;
      pwr = 0;
      if (acc_count != 0) begin
        rms = floor_root(acc_sum / acc_count);
        if (rms > RMS_FULL) rms = RMS_FULL;
        cur = rms * scale_reg;
        if (cur > CUR_FULL) cur = CUR_FULL;
        pwr = (cur * volt_reg) / MW_DIV;
      end
      r.rms_raw      = RMS_W'(rms);
      r.current_ua   = CUR_W'(cur);
      r.power_mw     = PWR_W'(pwr);
      r.window_count = WCNT_W'((acc_count > WCNT_FULL) ? WCNT_FULL : acc_count);
      r.window_empty = (acc_count == 0);
      r.saturated    = acc_over;
      report_q.push_back(r);
      acc_sum   = 0;
      acc_count = 0;
      acc_over  = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) track_word(in_cmd, in_sample);
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t result word: expected none, actual rms %0d count %0d", $time,
                   out_rms_raw, out_window_count);
        end else begin
          want_r = report_q.pop_front();
          check_field("rms_raw", want_r.rms_raw, out_rms_raw);
          check_field("current_ua", want_r.current_ua, out_current_ua);
          check_field("power_mw", want_r.power_mw, out_power_mw);
          check_field("window_count", want_r.window_count, out_window_count);
          check_field("window_empty", want_r.window_empty, out_window_empty);
          check_field("saturated", want_r.saturated, out_saturated);
        end
      end
    end
  end

  // receiver: random stall modes, plus a long hold when requested
  initial begin : rx_stall
    int hold_left;
    int mode_left;
    int mode;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_left = hold_len;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  task automatic send_word(input logic cmd, input logic [SAMP_W-1:0] samp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid  <= 1'b0;
        in_cmd    <= 1'($urandom);
        in_sample <= SAMP_W'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_sample <= samp;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= CFG_IDX_W'($urandom);
    cfg_wdata <= CFG_W'($urandom);
    if (idx == REG_SCALE) scale_reg = SCALE_W'(data);
    else if (idx == REG_VOLT) volt_reg = VOLT_W'(data);
  endtask

  function automatic logic [SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return SAMP_W'($urandom_range(0, 16)) - SAMP_W'(8);
      3: return {1'b1, 3'b000, 12'($urandom)};
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(16'hFFFF);
      3: return CFG_W'(SCALE_RST);
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_volt();
    case ($urandom_range(0, 5))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(500);
      3: return CFG_W'(16'hFFFF);
      default: return CFG_W'($urandom);
    endcase
  endfunction

  task automatic test_defaults();
    send_word(CMD_CLOSE, 16'h0000);
    send_word(CMD_SAMPLE, 16'd100);
    send_word(CMD_SAMPLE, -16'sd100);
    send_word(CMD_CLOSE, 16'hFFFF);
    send_word(CMD_CLOSE, 16'h1234);
  endtask

  task automatic test_sample_extremes();
    send_word(CMD_SAMPLE, 16'h7FFF);
    send_word(CMD_SAMPLE, 16'h8000);
    send_word(CMD_SAMPLE, 16'h0000);
    send_word(CMD_SAMPLE, 16'hFFFF);
    send_word(CMD_SAMPLE, 16'h0001);
    send_word(CMD_CLOSE, 16'h0000);
    send_word(CMD_SAMPLE, 16'h8000);
    send_word(CMD_CLOSE, 16'h0000);
    send_word(CMD_SAMPLE, 16'h7FFF);
    send_word(CMD_CLOSE, 16'h7FFF);
  endtask

  task automatic test_register_extremes();
    settle(CFG_SETTLE);
    write_reg(REG_SCALE, 16'hFFFF);
    write_reg(REG_VOLT, 16'hFFFF);
    send_word(CMD_SAMPLE, 16'h8000);
    send_word(CMD_CLOSE, 16'h0000);
    settle(CFG_SETTLE);
    write_reg(REG_UNUSED2, CFG_W'($urandom));
    write_reg(REG_UNUSED3, CFG_W'($urandom));
    send_word(CMD_SAMPLE, 16'h8000);
    send_word(CMD_SAMPLE, 16'h7FFF);
    send_word(CMD_CLOSE, 16'h0000);
    settle(CFG_SETTLE);
    write_reg(REG_SCALE, 16'h0000);
    send_word(CMD_SAMPLE, 16'd5);
    send_word(CMD_CLOSE, 16'h0000);
    settle(CFG_SETTLE);
    write_reg(REG_SCALE, 16'h0001);
    write_reg(REG_VOLT, 16'h0000);
    send_word(CMD_SAMPLE, 16'd5);
    send_word(CMD_CLOSE, 16'h0000);
    settle(CFG_SETTLE);
    write_reg(REG_SCALE, CFG_W'(SCALE_RST));
    write_reg(REG_VOLT, 16'd500);
  endtask

  task automatic test_random_windows();
    int start;
    int len;
    int pick;
    start = words_sent;
    while (words_sent - start < RAND_WORDS) begin
      pick = $urandom_range(0, 3);
      gap_max = (pick == 0) ? 0 : (pick == 1) ? 2 : (pick == 2) ? 6 : 30;
      if ($urandom_range(0, 4) == 0) begin
        settle(CFG_SETTLE);
        if ($urandom_range(0, 1)) write_reg(REG_SCALE, rand_scale());
        if ($urandom_range(0, 1)) write_reg(REG_VOLT, rand_volt());
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED2 | 1'($urandom), CFG_W'($urandom));
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_word(CMD_CLOSE, SAMP_W'($urandom));
        else send_word(CMD_SAMPLE, rand_sample());
      end
      send_word(CMD_CLOSE, SAMP_W'($urandom));
    end
  endtask

  task automatic test_output_backpressure();
    settle(CFG_SETTLE);
    gap_max = 0;
    @(negedge clk);
    hold_len = 700;
    hold_go = 1'b1;
    for (int i = 0; i < 3; i++) send_word(CMD_SAMPLE, rand_sample());
    send_word(CMD_CLOSE, 16'h0000);
    for (int i = 0; i < 10; i++) send_word(CMD_SAMPLE, rand_sample());
    send_word(CMD_CLOSE, 16'h0000);
    for (int i = 0; i < 5; i++) send_word(CMD_SAMPLE, rand_sample());
    send_word(CMD_CLOSE, 16'h0000);
    send_word(CMD_CLOSE, 16'h0000);
    settle(CFG_SETTLE);
  endtask

  initial begin
    errors     = 0;
    words_sent = 0;
    burst_left = 0;
    gap_max    = 4;
    hold_len   = 0;
    hold_go    = 1'b0;
    acc_sum    = 0;
    acc_count  = 0;
    acc_over   = 1'b0;
    scale_reg  = SCALE_RST;
    volt_reg   = VOLT_RST;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_cmd     = CMD_SAMPLE;
    in_sample  = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_SCALE;
    cfg_wdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_sample_extremes();
    test_register_extremes();
    test_random_windows();
    test_output_backpressure();

    settle(END_SETTLE);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
